[rtl/clu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clu_pkg
// Shared types and constants for the character stream lexer: token kind
// codes, scan mode codes, source limits and the token bundle format.
// ----------------------------------------------------------------------------
package clu_pkg;

  localparam int MAX_SOURCE_BYTES = 65536;
  localparam int MAX_LINES        = 65535;

  localparam int POS_CAP_INT  = (MAX_SOURCE_BYTES - 1 < 65535) ? MAX_SOURCE_BYTES - 1 : 65535;
  localparam int LINE_CAP_INT = (MAX_LINES < 65535) ? MAX_LINES : 65535;

  localparam logic [15:0] POS_CAP  = 16'(POS_CAP_INT);
  localparam logic [15:0] LINE_CAP = 16'(LINE_CAP_INT);

  localparam logic [4:0] K_LEFT_PAREN    = 5'd0;
  localparam logic [4:0] K_RIGHT_PAREN   = 5'd1;
  localparam logic [4:0] K_LEFT_BRACE    = 5'd2;
  localparam logic [4:0] K_RIGHT_BRACE   = 5'd3;
  localparam logic [4:0] K_COMMA         = 5'd4;
  localparam logic [4:0] K_DOT           = 5'd5;
  localparam logic [4:0] K_MINUS         = 5'd6;
  localparam logic [4:0] K_PLUS          = 5'd7;
  localparam logic [4:0] K_SEMICOLON     = 5'd8;
  localparam logic [4:0] K_SLASH         = 5'd9;
  localparam logic [4:0] K_STAR          = 5'd10;
  localparam logic [4:0] K_BANG          = 5'd11;
  localparam logic [4:0] K_BANG_EQUAL    = 5'd12;
  localparam logic [4:0] K_EQUAL         = 5'd13;
  localparam logic [4:0] K_EQUAL_EQUAL   = 5'd14;
  localparam logic [4:0] K_GREATER       = 5'd15;
  localparam logic [4:0] K_GREATER_EQUAL = 5'd16;
  localparam logic [4:0] K_LESS          = 5'd17;
  localparam logic [4:0] K_LESS_EQUAL    = 5'd18;
  localparam logic [4:0] K_STRING        = 5'd19;
  localparam logic [4:0] K_NUMBER        = 5'd20;
  localparam logic [4:0] K_IDENT         = 5'd21;
  localparam logic [4:0] K_END           = 5'd22;
  localparam logic [4:0] K_UNEXPECTED    = 5'd23;
  localparam logic [4:0] K_UNTERMINATED  = 5'd24;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_BANG    = 4'd1;
  localparam logic [3:0] M_EQ      = 4'd2;
  localparam logic [3:0] M_LT      = 4'd3;
  localparam logic [3:0] M_GT      = 4'd4;
  localparam logic [3:0] M_SLASH   = 4'd5;
  localparam logic [3:0] M_COMMENT = 4'd6;
  localparam logic [3:0] M_STRING  = 4'd7;
  localparam logic [3:0] M_NUMBER  = 4'd8;
  localparam logic [3:0] M_NUMDOT  = 4'd9;
  localparam logic [3:0] M_FRAC    = 4'd10;
  localparam logic [3:0] M_IDENT   = 4'd11;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
  } tok_t;

  typedef struct packed {
    logic [1:0]     count;
    logic [15:0]    line;
    tok_t [2:0]     toks;
  } bundle_t;

endpackage

[rtl/character_stream_lexer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// character_stream_lexer_unit
// Streaming lexical scanner: one source byte or end marker per input
// transaction, zero to three tokens out as kind, start, length and line.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_ready | char_byte, end_of_input
//   out     | out_valid/out_ready | token_kind, token_start, token_length,
//           |                     | token_line, last_of_run
//
// One input transaction per cycle while each byte yields at most one token and out_ready stays high.
// A byte that yields several tokens holds the result register until its last
// token is taken; the next byte waits in the input register and input stalls
// meanwhile, unless that waiting byte yields no token.
// A token reaches the output through the input register and then the result register.
// Synchronous reset clears the scan state to idle, offset 0, line 1.
// A stall on out_ready backs up through the result register into in_ready.
// ----------------------------------------------------------------------------
module character_stream_lexer_unit #(
  parameter int MAX_SOURCE_BYTES = clu_pkg::MAX_SOURCE_BYTES,
  parameter int MAX_LINES        = clu_pkg::MAX_LINES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [15:0] token_line,
  output logic        last_of_run
);
  import clu_pkg::*;

  bundle_t bundle;
  logic    bundle_valid;
  logic    bundle_ready;

  clu_scan #(
    .MAX_SOURCE_BYTES (MAX_SOURCE_BYTES),
    .MAX_LINES        (MAX_LINES)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_byte    (char_byte),
    .end_of_input (end_of_input),
    .bundle_valid (bundle_valid),
    .bundle_ready (bundle_ready),
    .bundle       (bundle)
  );

  clu_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (bundle_valid),
    .load_ready   (bundle_ready),
    .load_bundle  (bundle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .token_line   (token_line),
    .last_of_run  (last_of_run)
  );

endmodule

[rtl/clu_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clu_scan
// Input register, scan state and the single-pass step logic. Each accepted
// byte produces a bundle of zero to three tokens and the next scan state.
// ----------------------------------------------------------------------------
module clu_scan #(
  parameter int MAX_SOURCE_BYTES = clu_pkg::MAX_SOURCE_BYTES,
  parameter int MAX_LINES        = clu_pkg::MAX_LINES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       char_byte,
  input  logic             end_of_input,
  output logic             bundle_valid,
  input  logic             bundle_ready,
  output clu_pkg::bundle_t bundle
);
  import clu_pkg::*;

  localparam int POS_LIMIT_INT  = (MAX_SOURCE_BYTES - 1 < 65535) ? MAX_SOURCE_BYTES - 1 : 65535;
  localparam int LINE_LIMIT_INT = (MAX_LINES < 65535) ? MAX_LINES : 65535;

  localparam logic [15:0] POS_LIMIT  = 16'(POS_LIMIT_INT);
  localparam logic [15:0] LINE_LIMIT = 16'(LINE_LIMIT_INT);

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDER);
  endfunction

  function automatic logic [15:0] span(input logic [16:0] from, input logic [16:0] to);
    logic [16:0] d;
    d = (to > from) ? to - from : 17'd0;
    return d[16] ? 16'hFFFF : d[15:0];
  endfunction

  logic        q_valid;
  logic [7:0]  char_q;
  logic        eoi_q;
  logic [3:0]  mode;
  logic [15:0] pos;
  logic [15:0] start;
  logic [15:0] line;

  logic [3:0]  mode_next;
  logic [15:0] pos_next;
  logic [15:0] start_next;
  logic [15:0] line_next;

  logic        advance;
  logic        c_digit, c_alnum, c_eq, c_slash, c_quote, c_lf, c_dot;
  logic [16:0] pos_w, pos_w1, start_w;
  logic [15:0] dot_pos;
  logic [15:0] line_inc;

  logic        h0v, h1v, consumed, str_lf;
  tok_t        h0, h1;
  logic [3:0]  mode_h;
  logic [4:0]  single;

  logic        fv, f_lf;
  tok_t        ftok;
  logic [3:0]  mode_f;

  logic        tv;
  tok_t        tail;

  assign c_digit = !eoi_q && is_digit(char_q);
  assign c_alnum = !eoi_q && (is_digit(char_q) || is_alpha(char_q));
  assign c_eq    = !eoi_q && (char_q == CH_EQ);
  assign c_slash = !eoi_q && (char_q == CH_SLASH);
  assign c_quote = !eoi_q && (char_q == CH_QUOTE);
  assign c_lf    = !eoi_q && (char_q == CH_LF);
  assign c_dot   = !eoi_q && (char_q == CH_DOT);

  assign pos_w    = {1'b0, pos};
  assign pos_w1   = pos_w + 17'd1;
  assign start_w  = {1'b0, start};
  assign dot_pos  = (pos > start) ? pos - 16'd1 : start;
  assign line_inc = (line < LINE_LIMIT) ? line + 16'd1 : line;

  always_comb begin
    h0v      = 1'b0;
    h1v      = 1'b0;
    h0       = '0;
    h1       = '0;
    consumed = 1'b0;
    str_lf   = 1'b0;
    mode_h   = M_IDLE;
    unique case (mode)
      M_BANG:  single = K_BANG;
      M_EQ:    single = K_EQUAL;
      M_GT:    single = K_GREATER;
      default: single = K_LESS;
    endcase
    unique case (mode)
      M_BANG, M_EQ, M_LT, M_GT: begin
        h0v = 1'b1;
        if (c_eq) begin
          consumed = 1'b1;
          h0 = '{kind: single + 5'd1, start: start, length: span(start_w, pos_w1)};
        end else begin
          h0 = '{kind: single, start: start, length: 16'd1};
        end
      end
      M_SLASH: begin
        if (c_slash) begin
          consumed = 1'b1;
          mode_h   = M_COMMENT;
        end else begin
          h0v = 1'b1;
          h0  = '{kind: K_SLASH, start: start, length: 16'd1};
        end
      end
      M_COMMENT: begin
        if (!c_lf) begin
          consumed = 1'b1;
          mode_h   = M_COMMENT;
        end
      end
      M_STRING: begin
        consumed = 1'b1;
        if (eoi_q) begin
          h0v = 1'b1;
          h0  = '{kind: K_UNTERMINATED, start: start, length: span(start_w, pos_w)};
        end else if (c_quote) begin
          h0v = 1'b1;
          h0  = '{kind: K_STRING, start: start, length: span(start_w, pos_w1)};
        end else begin
          mode_h = M_STRING;
          str_lf = c_lf;
        end
      end
      M_NUMBER: begin
        if (c_digit) begin
          consumed = 1'b1;
          mode_h   = M_NUMBER;
        end else if (c_dot) begin
          consumed = 1'b1;
          mode_h   = M_NUMDOT;
        end else begin
          h0v = 1'b1;
          h0  = '{kind: K_NUMBER, start: start, length: span(start_w, pos_w)};
        end
      end
      M_NUMDOT: begin
        if (c_digit) begin
          consumed = 1'b1;
          mode_h   = M_FRAC;
        end else begin
          h0v = 1'b1;
          h1v = 1'b1;
          h0  = '{kind: K_NUMBER, start: start, length: span(start_w, {1'b0, dot_pos})};
          h1  = '{kind: K_DOT, start: dot_pos, length: 16'd1};
        end
      end
      M_FRAC: begin
        if (c_digit) begin
          consumed = 1'b1;
          mode_h   = M_FRAC;
        end else begin
          h0v = 1'b1;
          h0  = '{kind: K_NUMBER, start: start, length: span(start_w, pos_w)};
        end
      end
      M_IDENT: begin
        if (c_alnum) begin
          consumed = 1'b1;
          mode_h   = M_IDENT;
        end else begin
          h0v = 1'b1;
          h0  = '{kind: K_IDENT, start: start, length: span(start_w, pos_w)};
        end
      end
      default: begin
        consumed = 1'b0;
      end
    endcase
  end

  always_comb begin
    fv     = 1'b0;
    f_lf   = 1'b0;
    mode_f = M_IDLE;
    ftok   = '{kind: K_UNEXPECTED, start: pos, length: 16'd1};
    unique case (char_q)
      8'h28: begin fv = 1'b1; ftok.kind = K_LEFT_PAREN;  end
      8'h29: begin fv = 1'b1; ftok.kind = K_RIGHT_PAREN; end
      8'h7B: begin fv = 1'b1; ftok.kind = K_LEFT_BRACE;  end
      8'h7D: begin fv = 1'b1; ftok.kind = K_RIGHT_BRACE; end
      8'h2C: begin fv = 1'b1; ftok.kind = K_COMMA;       end
      CH_DOT: begin fv = 1'b1; ftok.kind = K_DOT;        end
      8'h2D: begin fv = 1'b1; ftok.kind = K_MINUS;       end
      8'h2B: begin fv = 1'b1; ftok.kind = K_PLUS;        end
      8'h3B: begin fv = 1'b1; ftok.kind = K_SEMICOLON;   end
      8'h2A: begin fv = 1'b1; ftok.kind = K_STAR;        end
      8'h21: mode_f = M_BANG;
      CH_EQ: mode_f = M_EQ;
      8'h3C: mode_f = M_LT;
      8'h3E: mode_f = M_GT;
      CH_SLASH: mode_f = M_SLASH;
      8'h20, 8'h0D, 8'h09: fv = 1'b0;
      CH_LF: f_lf = 1'b1;
      CH_QUOTE: mode_f = M_STRING;
      default: begin
        if (is_digit(char_q)) begin
          mode_f = M_NUMBER;
        end else if (is_alpha(char_q)) begin
          mode_f = M_IDENT;
        end else begin
          fv = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    if (eoi_q) begin
      tv   = 1'b1;
      tail = '{kind: K_END, start: pos, length: 16'd0};
    end else begin
      tv   = !consumed && fv;
      tail = ftok;
    end
    bundle.toks[0] = h0v ? h0 : tail;
    bundle.toks[1] = h1v ? h1 : tail;
    bundle.toks[2] = tail;
    bundle.count   = 2'(h0v) + 2'(h1v) + 2'(tv);
    bundle.line    = line;
  end

  assign bundle_valid = q_valid && (bundle.count != 2'd0);
  assign advance      = q_valid && ((bundle.count == 2'd0) || bundle_ready);
  assign in_ready     = !q_valid || advance;

  always_comb begin
    if (eoi_q) begin
      mode_next  = M_IDLE;
      pos_next   = 16'd0;
      start_next = 16'd0;
      line_next  = 16'd1;
    end else begin
      mode_next  = consumed ? mode_h : mode_f;
      pos_next   = (pos < POS_LIMIT) ? pos + 16'd1 : pos;
      start_next = consumed ? start : pos;
      line_next  = (str_lf || (!consumed && f_lf)) ? line_inc : line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q <= char_byte;
      eoi_q  <= end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      pos   <= 16'd0;
      start <= 16'd0;
      line  <= 16'd1;
    end else if (advance) begin
      mode  <= mode_next;
      pos   <= pos_next;
      start <= start_next;
      line  <= line_next;
    end
  end

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    (q_valid && eoi_q) |-> bundle_valid)
    else $error("end transaction produced no tokens");

  a_end_restores: assert property (@(posedge clk) disable iff (rst)
    (advance && eoi_q) |=> (mode == M_IDLE && pos == 16'd0 && start == 16'd0 && line == 16'd1))
    else $error("scan state not restored after end transaction");

  a_start_le_pos: assert property (@(posedge clk) disable iff (rst)
    start <= pos)
    else $error("lexeme start beyond byte position");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line != 16'd0)
    else $error("line count reached zero");

endmodule

[rtl/clu_drain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clu_drain
// Result register. Holds one token bundle and hands its tokens out one per
// transaction, flagging the last token of the bundle.
// ----------------------------------------------------------------------------
module clu_drain (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             load_ready,
  input  clu_pkg::bundle_t load_bundle,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [4:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic [15:0]      token_line,
  output logic             last_of_run
);
  import clu_pkg::*;

  bundle_t    bund;
  logic       busy;
  logic [1:0] idx;
  tok_t       cur;
  logic       last;

  assign cur          = bund.toks[idx];
  assign last         = (idx == bund.count - 2'd1);
  assign out_valid    = busy;
  assign token_kind   = cur.kind;
  assign token_start  = cur.start;
  assign token_length = cur.length;
  assign token_line   = bund.line;
  assign last_of_run  = last;
  assign load_ready   = !busy || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && out_ready) begin
      if (last) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      bund <= load_bundle;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bund.count != 2'd0 && idx < bund.count))
    else $error("token index outside bundle");

  a_idx_advance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run) |=> (out_valid && idx == $past(idx) + 2'd1))
    else $error("token index did not advance");

  a_load_first: assert property (@(posedge clk) disable iff (rst)
    (load_valid && load_ready) |=> (out_valid && idx == 2'd0))
    else $error("new bundle not presented from its first token");

endmodule
